### src/dpcm_rs_pkg.sv
// shared constants and types for the dpcm residual subtractor
package dpcm_rs_pkg;

  localparam int MAX_BLOCK_WIDTH_DEF  = 128;
  localparam int MAX_BLOCK_HEIGHT_DEF = 128;
  localparam int SAMPLE_BITS_DEF      = 16;

  localparam int SAMPLE_W    = 16;
  localparam int RESIDUAL_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int MODE_W      = 2;
  localparam int SIZE_CFG_W  = 8;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_DPCM_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_HEIGHT = 2'd2;

  // dpcm mode codes; the unused code behaves as plain
  localparam logic [MODE_W-1:0] MODE_PLAIN      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd2;

  localparam logic [SIZE_CFG_W-1:0] BLOCK_SIZE_RESET = 8'd4;

  // which stored residual is subtracted from the raw one
  typedef enum logic [1:0] {
    PRED_NONE,
    PRED_ABOVE,
    PRED_LEFT
  } pred_sel_t;

endpackage

### src/dpcm_rs_ram.sv
// generic single-write, single-read ram with registered read data
module dpcm_rs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/dpcm_residual_subtract.sv
// dpcm residual subtractor top level: counters, line store, residual pipeline
//
// Takes one source/prediction pair per cycle in raster order and returns one 16-bit
// residual per request, with end_of_row and end_of_block flags. A request is taken
// every cycle while the output side keeps up; a taken request passes through the
// line-store read and then the output register. The raw residual of each sample is
// written to the line store in the same cycle its column is read, so the read returns
// the row above with no forwarding. in_stall rises only when both the middle stage and
// the output register hold data and out_stall is high. No clearing pass is needed
// after reset.
module dpcm_residual_subtract #(
  parameter int MAX_BLOCK_WIDTH  = dpcm_rs_pkg::MAX_BLOCK_WIDTH_DEF,
  parameter int MAX_BLOCK_HEIGHT = dpcm_rs_pkg::MAX_BLOCK_HEIGHT_DEF,
  parameter int SAMPLE_BITS      = dpcm_rs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [dpcm_rs_pkg::SAMPLE_W-1:0]          source_sample,
  input  logic [dpcm_rs_pkg::SAMPLE_W-1:0]          predicted_sample,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [dpcm_rs_pkg::RESIDUAL_W-1:0] residual,
  output logic                                      end_of_row,
  output logic                                      end_of_block,
  input  logic                                      cfg_write,
  input  logic [dpcm_rs_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dpcm_rs_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import dpcm_rs_pkg::*;

  localparam int CW  = MAX_BLOCK_WIDTH > 1 ? $clog2(MAX_BLOCK_WIDTH) : 1;
  localparam int RW  = MAX_BLOCK_HEIGHT > 1 ? $clog2(MAX_BLOCK_HEIGHT) : 1;
  localparam int SW0 = (CW > RW ? CW : RW) + 1;
  localparam int SW  = SW0 > SIZE_CFG_W ? SW0 : SIZE_CFG_W;
  localparam int DW  = SAMPLE_BITS + 1;
  localparam int XW  = SAMPLE_BITS + 2 > RESIDUAL_W ? SAMPLE_BITS + 2 : RESIDUAL_W;

  // configuration
  logic [MODE_W-1:0]     dpcm_mode;
  logic [SIZE_CFG_W-1:0] block_width;
  logic [SIZE_CFG_W-1:0] block_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      dpcm_mode    <= MODE_PLAIN;
      block_width  <= BLOCK_SIZE_RESET;
      block_height <= BLOCK_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DPCM_MODE:    dpcm_mode    <= cfg_data[MODE_W-1:0];
        REG_BLOCK_WIDTH:  block_width  <= cfg_data[SIZE_CFG_W-1:0];
        REG_BLOCK_HEIGHT: block_height <= cfg_data[SIZE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective block size: zero acts as one, large values saturate
  logic [SW-1:0] width_x, height_x, width_sz, height_sz;

  always_comb begin
    width_x  = SW'(block_width);
    height_x = SW'(block_height);
    if (width_x == '0) begin
      width_sz = SW'(1);
    end else if (width_x > SW'(MAX_BLOCK_WIDTH)) begin
      width_sz = SW'(MAX_BLOCK_WIDTH);
    end else begin
      width_sz = width_x;
    end
    if (height_x == '0) begin
      height_sz = SW'(1);
    end else if (height_x > SW'(MAX_BLOCK_HEIGHT)) begin
      height_sz = SW'(MAX_BLOCK_HEIGHT);
    end else begin
      height_sz = height_x;
    end
  end

  // handshake and pipeline control
  logic in_accept;
  logic s1_valid;
  logic s1_advance;

  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  // position counters
  logic [CW-1:0] col_idx, col_idx_next;
  logic [RW-1:0] row_idx, row_idx_next;
  logic          last_col, last_row;

  assign last_col = (SW'(col_idx) + SW'(1)) >= width_sz;
  assign last_row = (SW'(row_idx) + SW'(1)) >= height_sz;

  always_comb begin
    col_idx_next = col_idx + CW'(1);
    row_idx_next = row_idx;
    if (last_col) begin
      col_idx_next = '0;
      row_idx_next = last_row ? '0 : row_idx + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx <= '0;
      row_idx <= '0;
    end else if (in_accept) begin
      col_idx <= col_idx_next;
      row_idx <= row_idx_next;
    end
  end

  // raw residual at the input
  logic [DW-1:0]        src_x, pred_x;
  logic signed [DW-1:0] raw;
  logic signed [DW-1:0] left_residual;
  pred_sel_t            sel;

  assign src_x  = {1'b0, source_sample[SAMPLE_BITS-1:0]};
  assign pred_x = {1'b0, predicted_sample[SAMPLE_BITS-1:0]};
  assign raw    = signed'(src_x - pred_x);

  always_comb begin
    sel = PRED_NONE;
    case (dpcm_mode)
      MODE_VERTICAL:   if (row_idx != '0) sel = PRED_ABOVE;
      MODE_HORIZONTAL: if (col_idx != '0) sel = PRED_LEFT;
      default:         sel = PRED_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_residual <= '0;
    end else if (in_accept) begin
      left_residual <= raw;
    end
  end

  // line store: read the row above and write this raw residual in the same cycle
  logic [DW-1:0] above_rd;

  dpcm_rs_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_BLOCK_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_accept),
    .waddr (col_idx),
    .wdata (raw),
    .re    (in_accept),
    .raddr (col_idx),
    .rdata (above_rd)
  );

  // middle stage, waits for the line-store data
  logic signed [DW-1:0] s1_raw, s1_left;
  pred_sel_t            s1_sel;
  logic                 s1_eor, s1_eob;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_raw  <= raw;
      s1_left <= left_residual;
      s1_sel  <= sel;
      s1_eor  <= last_col;
      s1_eob  <= last_col && last_row;
    end
  end

  logic signed [DW-1:0] s1_ref;
  logic signed [XW-1:0] diff;

  always_comb begin
    case (s1_sel)
      PRED_ABOVE: s1_ref = signed'(above_rd);
      PRED_LEFT:  s1_ref = s1_left;
      default:    s1_ref = '0;
    endcase
  end

  assign diff = XW'(s1_raw) - XW'(s1_ref);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      residual     <= diff[RESIDUAL_W-1:0];
      end_of_row   <= s1_eor;
      end_of_block <= s1_eob;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted request lost before the middle stage");

  a_last_col_wraps: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_col) |=> (col_idx == '0))
    else $error("column counter did not wrap at the row end");

  a_block_end_is_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_block || end_of_row))
    else $error("block end flagged off a row end");

endmodule
